/* rtl/core/tank_level_debounce_err_count_assert.svh */
// assertion macros for the tank level qualifier
// used by modules that carry concurrent checks; expects clk and rst_n in scope
`ifndef TANK_LEVEL_DEBOUNCE_ERR_COUNT_ASSERT_SVH
`define TANK_LEVEL_DEBOUNCE_ERR_COUNT_ASSERT_SVH

`ifndef ASSERT_OFF

// plain property that must hold at every edge out of reset
`define TLDEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TLDEC_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define TLDEC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define TLDEC_ASSERT(label, prop, msg)
`define TLDEC_ASSERT_IMP(label, pre, post, msg)
`define TLDEC_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

/* rtl/core/tldec_pkg.sv */
// shared types and constants for the tank level qualifier
// no dependencies; used by every module of the block
package tldec_pkg;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // level codes
    localparam logic [2:0] LVL_LOW         = 3'd0;
    localparam logic [2:0] LVL_MID         = 3'd1;
    localparam logic [2:0] LVL_HIGH        = 3'd2;
    localparam logic [2:0] LVL_OVERFLOW    = 3'd3;
    localparam logic [2:0] LVL_ERR_LOW     = 3'd4;
    localparam logic [2:0] LVL_ERR_HIGH    = 3'd5;
    localparam logic [2:0] LVL_ERR_COMPLEX = 3'd6;
    localparam logic [2:0] LVL_ERR_OVF_LOW = 3'd7;

    // error counter slots
    localparam logic [1:0] CNT_LOW      = 2'd0;
    localparam logic [1:0] CNT_COMPLEX  = 2'd1;
    localparam logic [1:0] CNT_HIGH     = 2'd2;
    localparam logic [1:0] CNT_OVF      = 2'd3;

    localparam logic [7:0] CNT_MAX      = 8'd255;
    localparam logic [7:0] DETECT_RESET = 8'd20;
    localparam logic [7:0] CLEAR_BELOW  = 8'd3;

    typedef logic [3:0][7:0] count_set_t;

    // one input word as held in the input register
    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] channel;
        logic [2:0] sensed_level;
        logic [1:0] error_type;
        logic [7:0] count_value;
    } item_t;

    // what the state store hands back for one word
    typedef struct packed {
        logic [2:0] level;
        count_set_t counts;
        logic [7:0] timer;
    } result_t;

endpackage

/* rtl/core/tldec_in_stage.sv */
// input register stage of the tank level qualifier
// depends on tldec_pkg for the item type
module tldec_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tldec_pkg::item_t in_item,
    input  logic           advance,
    output logic           held_valid,
    output tldec_pkg::item_t held_item
);

    logic             valid_reg;
    tldec_pkg::item_t item_reg;

    // room for a new word when empty or when the held one moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/core/tldec_chan_store.sv */
// per-channel level, timer and error counter state with its update logic
// depends on tldec_pkg for codes, item and result types
module tldec_chan_store
#(
    parameter int NUM_CHANNELS = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tldec_pkg::item_t item,
    input  logic [7:0]       settle_time,
    output tldec_pkg::result_t result
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [2:0]              pend_reg [NUM_CHANNELS];
    logic [2:0]              cur_reg  [NUM_CHANNELS];
    logic [7:0]              tmr_reg  [NUM_CHANNELS];
    tldec_pkg::count_set_t   cnt_reg  [NUM_CHANNELS];

    logic [CH_W+2:0]         ch_ext;
    logic [CH_W-1:0]         idx;
    logic                    ch_ok;
    logic [2:0]              lvl;

    logic [2:0]              sel_pend;
    logic [2:0]              sel_cur;
    logic [7:0]              sel_tmr;
    tldec_pkg::count_set_t   sel_cnt;
    logic [2:0]              pend_next;
    logic [2:0]              cur_next;
    logic [7:0]              tmr_next;
    tldec_pkg::count_set_t   cnt_next;
    tldec_pkg::count_set_t   room_next;

    assign ch_ext = {{CH_W{1'b0}}, item.channel};
    assign idx    = ch_ext[CH_W-1:0];
    assign ch_ok  = int'(item.channel) < NUM_CHANNELS;
    assign lvl    = item.sensed_level;

    always_comb
    begin
        sel_pend  = pend_reg[idx];
        sel_cur   = cur_reg[idx];
        sel_tmr   = tmr_reg[idx];
        sel_cnt   = cnt_reg[idx];
        pend_next = sel_pend;
        cur_next  = sel_cur;
        tmr_next  = sel_tmr;
        cnt_next  = sel_cnt;

        // room clear drops small overflow, complex and high counts of channel 0
        room_next = cnt_reg[0];
        if (room_next[tldec_pkg::CNT_OVF] < tldec_pkg::CLEAR_BELOW)
            room_next[tldec_pkg::CNT_OVF] = 8'd0;
        if (room_next[tldec_pkg::CNT_COMPLEX] < tldec_pkg::CLEAR_BELOW)
            room_next[tldec_pkg::CNT_COMPLEX] = 8'd0;
        if (room_next[tldec_pkg::CNT_HIGH] < tldec_pkg::CLEAR_BELOW)
            room_next[tldec_pkg::CNT_HIGH] = 8'd0;

        case (item.operation)
            tldec_pkg::OP_SAMPLE:
            begin
                if (sel_pend != lvl)
                begin
                    pend_next = lvl;
                    tmr_next  = settle_time;
                end
                else if (sel_tmr != 8'd0)
                begin
                    tmr_next = sel_tmr - 8'd1;
                end
                else
                begin
                    if (sel_cur != lvl)
                    begin
                        case (lvl) inside
                            tldec_pkg::LVL_ERR_LOW, tldec_pkg::LVL_ERR_OVF_LOW:
                            begin
                                if (sel_cnt[tldec_pkg::CNT_LOW] != tldec_pkg::CNT_MAX)
                                    cnt_next[tldec_pkg::CNT_LOW] =
                                        sel_cnt[tldec_pkg::CNT_LOW] + 8'd1;
                            end
                            tldec_pkg::LVL_ERR_COMPLEX:
                            begin
                                if (sel_cnt[tldec_pkg::CNT_COMPLEX] != tldec_pkg::CNT_MAX)
                                    cnt_next[tldec_pkg::CNT_COMPLEX] =
                                        sel_cnt[tldec_pkg::CNT_COMPLEX] + 8'd1;
                            end
                            tldec_pkg::LVL_ERR_HIGH:
                            begin
                                if (sel_cnt[tldec_pkg::CNT_HIGH] != tldec_pkg::CNT_MAX)
                                    cnt_next[tldec_pkg::CNT_HIGH] =
                                        sel_cnt[tldec_pkg::CNT_HIGH] + 8'd1;
                            end
                            tldec_pkg::LVL_OVERFLOW:
                            begin
                                if (sel_cnt[tldec_pkg::CNT_OVF] != tldec_pkg::CNT_MAX)
                                    cnt_next[tldec_pkg::CNT_OVF] =
                                        sel_cnt[tldec_pkg::CNT_OVF] + 8'd1;
                            end
                            tldec_pkg::LVL_HIGH:
                            begin
                                cnt_next[tldec_pkg::CNT_HIGH]    = 8'd0;
                                cnt_next[tldec_pkg::CNT_COMPLEX] = 8'd0;
                            end
                            default:
                            begin
                            end
                        endcase
                        // anything but a low-side error resets the low count
                        if (lvl != tldec_pkg::LVL_ERR_LOW && lvl != tldec_pkg::LVL_ERR_OVF_LOW)
                            cnt_next[tldec_pkg::CNT_LOW] = 8'd0;
                    end
                    cur_next = lvl;
                end
            end
            tldec_pkg::OP_SET:
            begin
                cnt_next[item.error_type] = item.count_value;
            end
            default:
            begin
            end
        endcase

        // result reflects the channel after this word
        if (!ch_ok)
        begin
            result = '0;
        end
        else
        begin
            result.level  = cur_next;
            result.timer  = tmr_next;
            result.counts = cnt_next;
            if (item.operation == tldec_pkg::OP_CLEAR && idx == CH_W'(0))
                result.counts = room_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pend_reg[i] <= tldec_pkg::LVL_LOW;
                cur_reg[i]  <= tldec_pkg::LVL_LOW;
                tmr_reg[i]  <= tldec_pkg::DETECT_RESET;
                cnt_reg[i]  <= '0;
            end
        end
        else if (fire)
        begin
            if (item.operation == tldec_pkg::OP_CLEAR)
            begin
                cnt_reg[0] <= room_next;
            end
            else if (ch_ok && (item.operation == tldec_pkg::OP_SAMPLE ||
                               item.operation == tldec_pkg::OP_SET))
            begin
                pend_reg[idx] <= pend_next;
                cur_reg[idx]  <= cur_next;
                tmr_reg[idx]  <= tmr_next;
                cnt_reg[idx]  <= cnt_next;
            end
        end
    end

endmodule

/* rtl/core/tank_level_debounce_err_count.sv */
// tank level qualifier, top level: one word in, one result word out per cycle while out_ready holds
// result path: an accepted word passes the input register, then the result register
// throughput: one word per cycle unless out_ready stalls; the per-channel state update is a single pass
// reset (rst_n, async, active low): all levels low, timers and settle time 20, counts zero
// depends on tldec_pkg, tldec_in_stage, tldec_chan_store and the assertion macro header
`include "tank_level_debounce_err_count_assert.svh"

module tank_level_debounce_err_count
#(
    parameter int NUM_CHANNELS = 5
)
(
    input  logic       clk,
    input  logic       rst_n,

    // configuration: settle time
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [2:0] channel,
    input  logic [2:0] sensed_level,
    input  logic [1:0] error_type,
    input  logic [7:0] count_value,

    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] accepted_level,
    output logic       is_full,
    output logic       is_error,
    output logic [7:0] count_low,
    output logic [7:0] count_complex,
    output logic [7:0] count_high,
    output logic [7:0] count_overflow,
    output logic [7:0] timer_left
);

    // settle time register; the user must write it only while the block is quiet, the block does not enforce it
    logic [7:0]         settle_time_reg;

    // input stage
    tldec_pkg::item_t   in_item;
    tldec_pkg::item_t   held_item;
    logic               held_valid;
    logic               advance;

    // result register
    logic               out_valid_reg;
    tldec_pkg::result_t res_comb;
    tldec_pkg::result_t res_reg;

    assign in_item.operation    = operation;
    assign in_item.channel      = channel;
    assign in_item.sensed_level = sensed_level;
    assign in_item.error_type   = error_type;
    assign in_item.count_value  = count_value;

    // held word moves into the result register when that is free or being drained
    assign advance = held_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_time_reg <= tldec_pkg::DETECT_RESET;
        end
        else if (cfg_wr_en)
        begin
            settle_time_reg <= cfg_wr_data;
        end
    end

    tldec_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // channel state is updated on the same edge that captures the result,
    // so the next word already sees it
    tldec_chan_store #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (held_item),
        .settle_time (settle_time_reg),
        .result      (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= held_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    // full from high upwards, error from overflow upwards
    assign out_valid      = out_valid_reg;
    assign accepted_level = res_reg.level;
    assign is_full        = (res_reg.level >= tldec_pkg::LVL_HIGH);
    assign is_error       = (res_reg.level >= tldec_pkg::LVL_OVERFLOW);
    assign count_low      = res_reg.counts[tldec_pkg::CNT_LOW];
    assign count_complex  = res_reg.counts[tldec_pkg::CNT_COMPLEX];
    assign count_high     = res_reg.counts[tldec_pkg::CNT_HIGH];
    assign count_overflow = res_reg.counts[tldec_pkg::CNT_OVF];
    assign timer_left     = res_reg.timer;

    // an empty input register must always take a word
    `TLDEC_ASSERT_IMP(a_ready_when_empty, !held_valid, in_ready, "input stage empty but not ready")
    // a result only appears after a word sat in the input register
    `TLDEC_ASSERT_IMP(a_result_has_source, $rose(out_valid_reg), $past(held_valid), "orphan result")
    // a stalled output must keep the held word in place
    `TLDEC_ASSERT_NEXT(a_no_drop_on_stall, held_valid && !advance, held_valid, "word dropped in stall")
    // error levels are always full levels
    `TLDEC_ASSERT_IMP(a_error_is_full, out_valid_reg && is_error, is_full, "error flag without full")

endmodule

/* tb/level_qual_check_pkg.sv */
// predictor and scoreboard for the tank level qualifier testbench
// depends on tldec_pkg for operation, level and counter codes
`timescale 1ns / 1ps

package level_qual_check_pkg;

    localparam int NUM_CH = 5;

    // channel numbers
    localparam logic [2:0] CH_ROOM  = 3'd0;
    localparam logic [2:0] CH_COLD  = 3'd1;
    localparam logic [2:0] CH_HOT   = 3'd2;
    localparam logic [2:0] CH_DRAIN = 3'd3;
    localparam logic [2:0] CH_ICE   = 3'd4;

    // one result word, fields in port order
    typedef struct packed {
        logic [2:0] level;
        logic       full;
        logic       err;
        logic [7:0] n_low;
        logic [7:0] n_complex;
        logic [7:0] n_high;
        logic [7:0] n_overflow;
        logic [7:0] timer;
    } level_report_t;

    class level_scoreboard;

        logic [7:0]    hold_ticks;
        logic [2:0]    pend_lvl [NUM_CH];
        logic [2:0]    qual_lvl [NUM_CH];
        logic [7:0]    settle_left [NUM_CH];
        logic [7:0]    err_cnt [NUM_CH][4];
        level_report_t expected_q [$];
        int unsigned   fails;
        int unsigned   words_in;
        int unsigned   checked;
        int unsigned   changes;

        function new();
            hold_ticks = tldec_pkg::DETECT_RESET;
            for (int c = 0; c < NUM_CH; c++)
            begin
                pend_lvl[c]    = tldec_pkg::LVL_LOW;
                qual_lvl[c]    = tldec_pkg::LVL_LOW;
                settle_left[c] = tldec_pkg::DETECT_RESET;
                for (int k = 0; k < 4; k++)
                    err_cnt[c][k] = 8'd0;
            end
            fails    = 0;
            words_in = 0;
            checked  = 0;
            changes  = 0;
        endfunction

        function void set_hold(logic [7:0] v);
            hold_ticks = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted word and queue the result it should give
        function void note_word(logic [1:0] op, logic [2:0] ch, logic [2:0] lvl,
                                logic [1:0] kind, logic [7:0] val);
            level_report_t r;
            bit            in_range;
            bit            do_bump;
            logic [1:0]    bump_kind;
            in_range  = (ch < NUM_CH);
            do_bump   = 1'b0;
            bump_kind = tldec_pkg::CNT_LOW;
            words_in++;
            if (op == tldec_pkg::OP_CLEAR)
            begin
                // room clear always hits channel 0, low count untouched
                for (int k = tldec_pkg::CNT_COMPLEX; k <= tldec_pkg::CNT_OVF; k++)
                    if (err_cnt[CH_ROOM][k] < tldec_pkg::CLEAR_BELOW)
                        err_cnt[CH_ROOM][k] = 8'd0;
            end
            else if (in_range && op == tldec_pkg::OP_SAMPLE)
            begin
                if (pend_lvl[ch] != lvl)
                begin
                    pend_lvl[ch]    = lvl;
                    settle_left[ch] = hold_ticks;
                end
                else if (settle_left[ch] != 8'd0)
                    settle_left[ch] = settle_left[ch] - 8'd1;
                else if (qual_lvl[ch] != lvl)
                begin
                    changes++;
                    qual_lvl[ch] = lvl;
                    case (lvl) inside
                        tldec_pkg::LVL_ERR_LOW, tldec_pkg::LVL_ERR_OVF_LOW:
                        begin
                            do_bump   = 1'b1;
                            bump_kind = tldec_pkg::CNT_LOW;
                        end
                        tldec_pkg::LVL_ERR_COMPLEX:
                        begin
                            do_bump   = 1'b1;
                            bump_kind = tldec_pkg::CNT_COMPLEX;
                        end
                        tldec_pkg::LVL_ERR_HIGH:
                        begin
                            do_bump   = 1'b1;
                            bump_kind = tldec_pkg::CNT_HIGH;
                        end
                        tldec_pkg::LVL_OVERFLOW:
                        begin
                            do_bump   = 1'b1;
                            bump_kind = tldec_pkg::CNT_OVF;
                        end
                        tldec_pkg::LVL_HIGH:
                        begin
                            err_cnt[ch][tldec_pkg::CNT_HIGH]    = 8'd0;
                            err_cnt[ch][tldec_pkg::CNT_COMPLEX] = 8'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (do_bump && err_cnt[ch][bump_kind] != tldec_pkg::CNT_MAX)
                        err_cnt[ch][bump_kind] = err_cnt[ch][bump_kind] + 8'd1;
                    if (lvl != tldec_pkg::LVL_ERR_LOW && lvl != tldec_pkg::LVL_ERR_OVF_LOW)
                        err_cnt[ch][tldec_pkg::CNT_LOW] = 8'd0;
                end
            end
            else if (in_range && op == tldec_pkg::OP_SET)
                err_cnt[ch][kind] = val;

            r = '0;
            if (in_range)
            begin
                r.level      = qual_lvl[ch];
                r.full       = (qual_lvl[ch] >= tldec_pkg::LVL_HIGH);
                r.err        = (qual_lvl[ch] >= tldec_pkg::LVL_OVERFLOW);
                r.n_low      = err_cnt[ch][tldec_pkg::CNT_LOW];
                r.n_complex  = err_cnt[ch][tldec_pkg::CNT_COMPLEX];
                r.n_high     = err_cnt[ch][tldec_pkg::CNT_HIGH];
                r.n_overflow = err_cnt[ch][tldec_pkg::CNT_OVF];
                r.timer      = settle_left[ch];
            end
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                fails++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(level_report_t got);
            level_report_t want;
            if (expected_q.size() == 0)
            begin
                fails++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            field_check("accepted_level", 8'(want.level), 8'(got.level));
            field_check("is_full", 8'(want.full), 8'(got.full));
            field_check("is_error", 8'(want.err), 8'(got.err));
            field_check("count_low", want.n_low, got.n_low);
            field_check("count_complex", want.n_complex, got.n_complex);
            field_check("count_high", want.n_high, got.n_high);
            field_check("count_overflow", want.n_overflow, got.n_overflow);
            field_check("timer_left", want.timer, got.timer);
        endfunction

    endclass

endpackage

/* tb/tb_tank_level_debounce_err_count.sv */
// testbench top for tank_level_debounce_err_count: directed and random words under
// several detect times and idling mixes, every result checked against a predictor
// depends on tldec_pkg, level_qual_check_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_tank_level_debounce_err_count;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] operation;
    logic [2:0] channel;
    logic [2:0] sensed_level;
    logic [1:0] error_type;
    logic [7:0] count_value;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] accepted_level;
    logic       is_full;
    logic       is_error;
    logic [7:0] count_low;
    logic [7:0] count_complex;
    logic [7:0] count_high;
    logic [7:0] count_overflow;
    logic [7:0] timer_left;

    // idling mix of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    level_qual_check_pkg::level_scoreboard level_sb = new();

    tank_level_debounce_err_count dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .channel        (channel),
        .sensed_level   (sensed_level),
        .error_type     (error_type),
        .count_value    (count_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted_level (accepted_level),
        .is_full        (is_full),
        .is_error       (is_error),
        .count_low      (count_low),
        .count_complex  (count_complex),
        .count_high     (count_high),
        .count_overflow (count_overflow),
        .timer_left     (timer_left)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: ready decided afresh at every falling edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // outputs sampled at the rising edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            level_sb.check_result({accepted_level, is_full, is_error, count_low,
                                   count_complex, count_high, count_overflow, timer_left});
    end

    // present one word from a falling edge; returns at the falling edge after it is taken,
    // with valid still high so the caller either follows straight on or drops it
    task automatic send_word(input logic [1:0] op, input logic [2:0] ch, input logic [2:0] lvl,
                             input logic [1:0] kind, input logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        channel      <= ch;
        sensed_level <= lvl;
        error_type   <= kind;
        count_value  <= val;
        do
            @(posedge clk);
        while (!in_ready);
        level_sb.note_word(op, ch, lvl, kind, val);
        @(negedge clk);
    endtask

    // a run of sample ticks of one level on one channel, other fields random
    task automatic send_run(input logic [2:0] ch, input logic [2:0] lvl, input int n);
        for (int i = 0; i < n; i++)
            send_word(tldec_pkg::OP_SAMPLE, ch, lvl, 2'($urandom_range(3)), 8'($urandom));
    endtask

    // detect time is only changed with the block drained and quiet
    task automatic write_detect(input logic [7:0] v);
        in_valid <= 1'b0;
        while (level_sb.pending() != 0)
            @(negedge clk);
        // two-stage pipe, leave a little margin
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        level_sb.set_hold(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random words: mostly stable runs that get a level qualified, the rest
    // sets, room clears and plain noise on any channel
    task automatic run_phase(input logic [7:0] detect, input int idle_pct,
                             input int stall_pct, input int n_words);
        int         sent;
        int         pick;
        int         run_len;
        logic [7:0] v;
        sent = 0;
        write_detect(detect);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                // long enough to qualify when the detect time is short
                if (detect < 8'd8)
                    run_len = detect + 2 + $urandom_range(2);
                else
                    run_len = 1 + $urandom_range(4);
                send_run(3'($urandom_range(level_qual_check_pkg::NUM_CH - 1)),
                         3'($urandom_range(7)), run_len);
                sent += run_len;
            end
            else if (pick < 77)
            begin
                // near the saturation point or around the room clear threshold
                case ($urandom_range(4))
                    0: v = tldec_pkg::CNT_MAX;
                    1: v = tldec_pkg::CNT_MAX - 8'd1;
                    2: v = tldec_pkg::CLEAR_BELOW - 8'd1;
                    3: v = tldec_pkg::CLEAR_BELOW;
                    default: v = 8'($urandom);
                endcase
                send_word(tldec_pkg::OP_SET, 3'($urandom_range(7)), 3'($urandom_range(7)),
                          2'($urandom_range(3)), v);
                sent++;
            end
            else if (pick < 85)
            begin
                send_word(tldec_pkg::OP_CLEAR, 3'($urandom_range(7)), 3'($urandom_range(7)),
                          2'($urandom_range(3)), 8'($urandom));
                sent++;
            end
            else
            begin
                send_word(2'($urandom_range(3)), 3'($urandom_range(7)),
                          3'($urandom_range(7)), 2'($urandom_range(3)), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 8'd0;
        in_valid     = 1'b0;
        operation    = tldec_pkg::OP_READ;
        channel      = level_qual_check_pkg::CH_ROOM;
        sensed_level = tldec_pkg::LVL_LOW;
        error_type   = tldec_pkg::CNT_LOW;
        count_value  = 8'd0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // state straight out of reset, then a channel beyond the last with all fields high
        send_word(tldec_pkg::OP_READ, level_qual_check_pkg::CH_ROOM, tldec_pkg::LVL_LOW,
                  tldec_pkg::CNT_LOW, 8'd0);
        send_word(tldec_pkg::OP_READ, 3'd7, tldec_pkg::LVL_ERR_OVF_LOW, tldec_pkg::CNT_OVF,
                  tldec_pkg::CNT_MAX);

        // zero detect time: a level qualifies on its second tick in a row
        write_detect(8'd0);
        send_run(level_qual_check_pkg::CH_COLD, tldec_pkg::LVL_OVERFLOW, 2);
        send_run(level_qual_check_pkg::CH_COLD, tldec_pkg::LVL_ERR_LOW, 2);
        send_run(level_qual_check_pkg::CH_COLD, tldec_pkg::LVL_ERR_OVF_LOW, 2);
        send_run(level_qual_check_pkg::CH_COLD, tldec_pkg::LVL_ERR_COMPLEX, 2);
        send_run(level_qual_check_pkg::CH_COLD, tldec_pkg::LVL_ERR_HIGH, 2);
        // high wipes the high and complex counts
        send_run(level_qual_check_pkg::CH_COLD, tldec_pkg::LVL_HIGH, 2);

        // overflow count already at the top must stay there
        send_word(tldec_pkg::OP_SET, level_qual_check_pkg::CH_HOT, tldec_pkg::LVL_LOW,
                  tldec_pkg::CNT_OVF, tldec_pkg::CNT_MAX);
        send_run(level_qual_check_pkg::CH_HOT, tldec_pkg::LVL_OVERFLOW, 2);

        // room clear issued on another channel: counts below three go, three stays
        send_word(tldec_pkg::OP_SET, level_qual_check_pkg::CH_ROOM, tldec_pkg::LVL_LOW,
                  tldec_pkg::CNT_HIGH, 8'd2);
        send_word(tldec_pkg::OP_SET, level_qual_check_pkg::CH_ROOM, tldec_pkg::LVL_LOW,
                  tldec_pkg::CNT_COMPLEX, 8'd3);
        send_word(tldec_pkg::OP_SET, level_qual_check_pkg::CH_ROOM, tldec_pkg::LVL_LOW,
                  tldec_pkg::CNT_OVF, 8'd1);
        send_word(tldec_pkg::OP_CLEAR, level_qual_check_pkg::CH_ICE, tldec_pkg::LVL_MID,
                  tldec_pkg::CNT_LOW, 8'd0);

        // out-of-range channels: clear still acts on the room, others do nothing
        send_word(tldec_pkg::OP_CLEAR, 3'd6, tldec_pkg::LVL_LOW, tldec_pkg::CNT_LOW, 8'd0);
        send_word(tldec_pkg::OP_SAMPLE, 3'd5, tldec_pkg::LVL_ERR_OVF_LOW, tldec_pkg::CNT_OVF,
                  tldec_pkg::CNT_MAX);
        send_word(tldec_pkg::OP_SET, 3'd7, tldec_pkg::LVL_LOW, tldec_pkg::CNT_LOW, 8'd9);
        send_word(tldec_pkg::OP_READ, level_qual_check_pkg::CH_ROOM, tldec_pkg::LVL_LOW,
                  tldec_pkg::CNT_LOW, 8'd0);

        // random phases, each with its own detect time and idling mix
        run_phase(8'd2, 0, 0, 30);
        run_phase(8'd0, 86, 0, 30);
        run_phase(tldec_pkg::CNT_MAX, 0, 86, 30);
        // one full countdown from the longest detect time
        send_run(level_qual_check_pkg::CH_DRAIN, tldec_pkg::LVL_ERR_COMPLEX, 257);
        run_phase(8'($urandom_range(1, 6)), 23, 23, 30);

        // drain and let the pipe settle
        in_valid <= 1'b0;
        while (level_sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("run: %0d words in, %0d results checked, %0d level changes qualified",
                 level_sb.words_in, level_sb.checked, level_sb.changes);
        $display("detect times 0, 2, 255 and one small random value; %0d mismatches",
                 level_sb.fails);
        if (level_sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still outstanding", level_sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tldec_pkg.sv
rtl/core/tldec_in_stage.sv
rtl/core/tldec_chan_store.sv
rtl/core/tank_level_debounce_err_count.sv
tb/level_qual_check_pkg.sv
tb/tb_tank_level_debounce_err_count.sv
